// ----- rtl/assert_macros.svh -----
// Assertion macros for checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/hpam_pkg.sv -----
// Types and codes for the hashed page allocator memory.
// No dependencies.
package hpam_pkg;
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_SEARCH = 3'd1, OP_WRITE = 3'd2,
    OP_READ = 3'd3, OP_DELETE = 3'd4, OP_PRINT = 3'd5
  } op_t;
  typedef enum logic [2:0] {
    ST_SUCCESS = 3'd0, ST_FAILURE = 3'd1, ST_FOUND = 3'd2, ST_NOTFOUND = 3'd3,
    ST_EMPTY = 3'd4, ST_ENTRY = 3'd5, ST_READ = 3'd6
  } status_t;
  typedef struct packed {
    logic [2:0] op;
    logic [31:0] pid;
    logic [15:0] offset;
    logic signed [63:0] value;
    logic [7:0] bucket;
  } in_item_t;
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_bucket;
    logic [15:0] echo_offset;
    logic signed [63:0] data;
    logic [31:0] chain_pid;
    logic last;
  } out_item_t;
  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_EXEC, S_MEMRD, S_MEMWAIT, S_PSCAN, S_PEMIT, S_OUT
  } state_t;
endpackage

// ----- rtl/hpam_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module hpam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/hashed_page_allocator_memory.sv -----
// Hashed page allocator with a per-process page of words.
// Depends on hpam_pkg and hpam_ram.
// After reset a clearing pass zeroes the word store; no item is taken meanwhile.
// A scan visits one entry slot a cycle: insert, search, delete and write scan
// every slot and then execute, read then adds a RAM read and a wait state, and
// print scans all slots once per listed PID, or once for an empty chain, and
// answers without a scan for a bucket out of range. Results leave through an
// output register; one item is worked at a time.
module hashed_page_allocator_memory #(
  parameter int PAGES = 16,
  parameter int PAGE_WORDS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hpam_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hpam_pkg::out_item_t    out_data
);
  import hpam_pkg::*;
  localparam int SW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW = $clog2(PAGES + 1);
  localparam int DEPTH = PAGES * PAGE_WORDS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic [31:0] epid_r [PAGES];
  logic [SW-1:0] fstk_r [PAGES];
  logic [PAGES-1:0] evld_r, evld_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt, idx_r, idx_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic hit_r, hit_nxt, got_r, got_nxt, any_r, any_nxt;
  logic more_r, more_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [31:0] best_r, best_nxt;
  logic [32:0] bound_r, bound_nxt;
  logic pid_we, stk_we;
  logic [SW-1:0] stk_idx, pid_slot;
  logic [SW-1:0] stk_val;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0] ram_wd, ram_rd;
  logic [SW-1:0] cur;
  logic [SW-1:0] bkt_of;
  logic [SW-1:0] top_page;
  logic cand_b;
  logic match_b;

  hpam_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign cur = idx_r[SW-1:0];
  assign bkt_of = SW'(epid_r[cur] % PAGES);
  assign top_page = fstk_r[SW'(fcnt_r - CW'(1))];
  assign cand_b = evld_r[cur] && (32'(bkt_of) == 32'(item_r.bucket))
                  && ({1'b0, epid_r[cur]} < bound_r);
  assign match_b = cand_b && (!got_r || epid_r[cur] > best_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      evld_r <= '0;
      fcnt_r <= CW'(PAGES);
      clr_r <= '0;
      for (int i = 0; i < PAGES; i++) fstk_r[i] <= SW'(i);
    end else begin
      state_r <= state_nxt;
      evld_r <= evld_nxt;
      fcnt_r <= fcnt_nxt;
      clr_r <= clr_nxt;
      if (stk_we) fstk_r[stk_idx] <= stk_val;
    end
    if (pid_we) epid_r[pid_slot] <= item_r.pid;
    item_r <= item_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    got_r <= got_nxt;
    any_r <= any_nxt;
    more_r <= more_nxt;
    slot_r <= slot_nxt;
    best_r <= best_nxt;
    bound_r <= bound_nxt;
  end

  function automatic out_item_t mk(status_t s);
    out_item_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    res_nxt = res_r;
    evld_nxt = evld_r;
    fcnt_nxt = fcnt_r;
    clr_nxt = clr_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    got_nxt = got_r;
    any_nxt = any_r;
    more_nxt = more_r;
    slot_nxt = slot_r;
    best_nxt = best_r;
    bound_nxt = bound_r;
    pid_we = 1'b0;
    pid_slot = '0;
    stk_we = 1'b0;
    stk_idx = '0;
    stk_val = '0;
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wd = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == 32'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          got_nxt = 1'b0;
          any_nxt = 1'b0;
          more_nxt = 1'b0;
          bound_nxt = 33'h1_0000_0000;
          if (in_data.op == OP_PRINT) begin
            if (32'(in_data.bucket) >= 32'(PAGES)) begin
              res_nxt = mk(ST_FAILURE);
              state_nxt = S_OUT;
            end else state_nxt = S_PSCAN;
          end else state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (evld_r[cur] && epid_r[cur] == item_r.pid) begin
          hit_nxt = 1'b1;
          slot_nxt = cur;
        end
        idx_nxt = idx_r + CW'(1);
        if (32'(idx_r) == 32'(PAGES - 1)) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        res_nxt = mk(ST_FAILURE);
        ram_addr = AW'(32'(slot_r) * PAGE_WORDS + 32'(item_r.offset));
        priority case (item_r.op)
          OP_INSERT: if (!hit_r && fcnt_r != '0) begin
            fcnt_nxt = fcnt_r - CW'(1);
            pid_we = 1'b1;
            pid_slot = top_page;
            evld_nxt[top_page] = 1'b1;
            res_nxt = mk(ST_SUCCESS);
          end
          OP_SEARCH: begin
            res_nxt = mk(hit_r ? ST_FOUND : ST_NOTFOUND);
            if (hit_r) res_nxt.found_bucket = 8'(item_r.pid % PAGES);
          end
          OP_WRITE: if (hit_r && 32'(item_r.offset) < 32'(PAGE_WORDS)) begin
            ram_we = 1'b1;
            ram_wd = item_r.value;
            res_nxt = mk(ST_SUCCESS);
          end
          OP_READ: if (hit_r && 32'(item_r.offset) < 32'(PAGE_WORDS)) begin
            state_nxt = S_MEMRD;
          end
          OP_DELETE: if (hit_r && 32'(fcnt_r) < 32'(PAGES)) begin
            stk_we = 1'b1;
            stk_idx = SW'(fcnt_r);
            stk_val = slot_r;
            fcnt_nxt = fcnt_r + CW'(1);
            evld_nxt[slot_r] = 1'b0;
            res_nxt = mk(ST_SUCCESS);
          end
          default: res_nxt = mk(ST_FAILURE);
        endcase
      end
      S_MEMRD: begin
        ram_addr = AW'(32'(slot_r) * PAGE_WORDS + 32'(item_r.offset));
        state_nxt = S_MEMWAIT;
      end
      S_MEMWAIT: begin
        res_nxt = mk(ST_READ);
        res_nxt.echo_offset = item_r.offset;
        res_nxt.data = ram_rd;
        state_nxt = S_OUT;
      end
      S_PSCAN: begin
        if (cand_b && got_r) more_nxt = 1'b1;
        if (match_b) begin
          got_nxt = 1'b1;
          best_nxt = epid_r[cur];
        end
        idx_nxt = idx_r + CW'(1);
        if (32'(idx_r) == 32'(PAGES - 1)) state_nxt = S_PEMIT;
      end
      S_PEMIT: begin
        idx_nxt = '0;
        got_nxt = 1'b0;
        more_nxt = 1'b0;
        bound_nxt = {1'b0, best_r};
        if (!got_r) begin
          res_nxt = mk(ST_EMPTY);
          state_nxt = S_OUT;
        end else begin
          res_nxt = mk(ST_ENTRY);
          res_nxt.chain_pid = best_r;
          res_nxt.last = !more_r;
          any_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (item_r.op == OP_PRINT && any_r && !res_r.last) begin
            state_nxt = S_PSCAN;
          end else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/hpam_checker.sv -----
// Port-level checks for the hashed page allocator memory.
// Depends on assert_macros.svh and hpam_pkg.
`include "assert_macros.svh"
module hpam_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hpam_pkg::out_item_t out_data
);
  import hpam_pkg::*;
  `CHK_IMPLY(a_busy, clk, rst_n, out_valid, !in_ready, "ready while result pending")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "dropped")
  `CHK_IMPLY(a_stat, clk, rst_n, out_valid, out_data.status <= ST_READ, "bad status")
  `CHK_IMPLY(a_nolast, clk, rst_n, out_valid && !out_data.last, out_data.status == ST_ENTRY, "non-final non-entry")
  `CHK_NEXT(a_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
endmodule

bind hashed_page_allocator_memory hpam_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- tb/tb.sv -----
// Testbench for hashed_page_allocator_memory: directed table then random commands.
// Depends on hpam_pkg and the block; carries its own model of pages, chains and words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpam_pkg::*;

  localparam int NPG = 16;
  localparam int NWD = 16;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  hashed_page_allocator_memory #(.PAGES(NPG), .PAGE_WORDS(NWD)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] mem_words [NPG*NWD];
  logic [3:0]  free_stack [NPG];
  int          free_num;
  logic [31:0] slot_pid [NPG];
  logic        slot_used [NPG];
  out_item_t   pending_q [$];
  int          err_count = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          long_hold = 0;
  int          quiet_cycles = 0;
  logic [31:0] pid_pool [24];

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t res;
  } row_t;

  function automatic out_item_t mk_res(status_t st, logic [7:0] fb, logic [15:0] off,
                                       logic [63:0] d, logic [31:0] cp, logic lst);
    out_item_t r;
    r.status = st;
    r.found_bucket = fb;
    r.echo_offset = off;
    r.data = d;
    r.chain_pid = cp;
    r.last = lst;
    return r;
  endfunction

  function automatic in_item_t mk_cmd(logic [2:0] op, logic [31:0] pid, logic [15:0] off,
                                      logic [63:0] v, logic [7:0] b);
    in_item_t c;
    c.op = op;
    c.pid = pid;
    c.offset = off;
    c.value = v;
    c.bucket = b;
    return c;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_res(out_item_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic predict_page_op(in_item_t c);
    int slot;
    int addr;
    logic [31:0] chain [$];
    slot = -1;
    for (int i = 0; i < NPG; i++)
      if (slot_used[i] && slot_pid[i] == c.pid && slot < 0) slot = i;
    case (c.op)
      OP_INSERT: begin
        if (free_num == 0 || slot >= 0) begin
          add_res(mk_res(ST_FAILURE, 0, 0, 0, 0, 1));
        end else begin
          free_num--;
          slot = free_stack[free_num];
          slot_pid[slot] = c.pid;
          slot_used[slot] = 1'b1;
          add_res(mk_res(ST_SUCCESS, 0, 0, 0, 0, 1));
        end
      end
      OP_SEARCH: begin
        if (slot >= 0) add_res(mk_res(ST_FOUND, 8'(c.pid % NPG), 0, 0, 0, 1));
        else add_res(mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1));
      end
      OP_WRITE, OP_READ: begin
        if (slot < 0 || c.offset >= NWD) begin
          add_res(mk_res(ST_FAILURE, 0, 0, 0, 0, 1));
        end else begin
          addr = slot * NWD + c.offset;
          if (c.op == OP_WRITE) begin
            mem_words[addr] = c.value;
            add_res(mk_res(ST_SUCCESS, 0, 0, 0, 0, 1));
          end else begin
            add_res(mk_res(ST_READ, 0, c.offset, mem_words[addr], 0, 1));
          end
        end
      end
      OP_DELETE: begin
        if (slot < 0 || free_num >= NPG) begin
          add_res(mk_res(ST_FAILURE, 0, 0, 0, 0, 1));
        end else begin
          free_stack[free_num] = 4'(slot);
          free_num++;
          slot_used[slot] = 1'b0;
          add_res(mk_res(ST_SUCCESS, 0, 0, 0, 0, 1));
        end
      end
      OP_PRINT: begin
        if (c.bucket >= NPG) begin
          add_res(mk_res(ST_FAILURE, 0, 0, 0, 0, 1));
        end else begin
          for (int i = 0; i < NPG; i++)
            if (slot_used[i] && (slot_pid[i] % NPG) == c.bucket)
              chain.insert(chain.size(), slot_pid[i]);
          chain.rsort();
          if (chain.size() == 0) add_res(mk_res(ST_EMPTY, 0, 0, 0, 0, 1));
          foreach (chain[k])
            add_res(mk_res(ST_ENTRY, 0, 0, 0, chain[k], k == chain.size() - 1));
        end
      end
      default: add_res(mk_res(ST_FAILURE, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic send_cmd(in_item_t c, bit typed, out_item_t res);
    int n0;
    while ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = c;
    do @(posedge clk); while (!in_ready);
    n0 = pending_q.size();
    predict_page_op(c);
    if (typed) begin
      while (pending_q.size() > n0) void'(pending_q.pop_back());
      add_res(res);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_item_t rand_cmd();
    in_item_t c;
    int w;
    w = $urandom_range(99);
    if (w < 26) c.op = OP_INSERT;
    else if (w < 40) c.op = OP_DELETE;
    else if (w < 56) c.op = OP_WRITE;
    else if (w < 74) c.op = OP_READ;
    else if (w < 84) c.op = OP_SEARCH;
    else if (w < 96) c.op = OP_PRINT;
    else c.op = 3'($urandom_range(7, 6));
    c.pid = ($urandom_range(9) == 0) ? $urandom : pid_pool[$urandom_range(23)];
    c.offset = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(NWD - 1));
    c.value = {$urandom, $urandom};
    c.bucket = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NPG - 1));
    return c;
  endfunction

  always @(negedge clk) begin
    if (long_hold) begin
      out_ready = 1'b0;
      repeat (300) @(negedge clk);
      long_hold = 0;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d", out_data.status));
      end else begin
        want = pending_q.pop_front();
        if (out_data.status !== want.status)
          report($sformatf("status %0d want %0d", out_data.status, want.status));
        if (out_data.found_bucket !== want.found_bucket)
          report($sformatf("found_bucket %0d want %0d", out_data.found_bucket,
                           want.found_bucket));
        if (out_data.echo_offset !== want.echo_offset)
          report($sformatf("echo_offset %0d want %0d", out_data.echo_offset,
                           want.echo_offset));
        if (out_data.data !== want.data)
          report($sformatf("data %h want %h", out_data.data, want.data));
        if (out_data.chain_pid !== want.chain_pid)
          report($sformatf("chain_pid %h want %h", out_data.chain_pid, want.chain_pid));
        if (out_data.last !== want.last)
          report($sformatf("last %0d want %0d", out_data.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  row_t rows [$];

  initial begin
    for (int i = 0; i < NPG * NWD; i++) mem_words[i] = '0;
    for (int i = 0; i < NPG; i++) begin
      free_stack[i] = 4'(i);
      slot_used[i] = 1'b0;
      slot_pid[i] = '0;
    end
    free_num = NPG;
    for (int i = 0; i < 24; i++) pid_pool[i] = ($urandom & ~32'hF) | (i % 6);
    pid_pool[0] = 32'h0;
    pid_pool[1] = 32'hFFFF_FFFF;

    rows.insert(rows.size(), '{mk_cmd(OP_SEARCH, 0, 0, 0, 0), 1,
                               mk_res(ST_NOTFOUND, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_PRINT, 0, 0, 0, 0), 1,
                               mk_res(ST_EMPTY, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_PRINT, 0, 0, 0, 8'hFF), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(3'd6, 7, 0, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(3'd7, 7, 0, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_READ, 5, 0, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_WRITE, 5, 0, 1, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_DELETE, 5, 0, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_INSERT, 0, 0, 0, 0), 1,
                               mk_res(ST_SUCCESS, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_INSERT, 16, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_INSERT, 32, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_INSERT, 0, 0, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_READ, 0, 0, 0, 0), 1,
                               mk_res(ST_READ, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_WRITE, 0, 15, 64'h7FFF_FFFF_FFFF_FFFF, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_WRITE, 0, 16, 1, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_READ, 0, 15, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_WRITE, 32'hFFFF_FFFF, 0, 64'h8000_0000_0000_0000, 0),
                               0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_READ, 32'hFFFF_FFFF, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_READ, 32'hFFFF_FFFF, 16'hFFFF, 0, 0), 1,
                               mk_res(ST_FAILURE, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_cmd(OP_PRINT, 0, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_PRINT, 0, 0, 0, 15), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_SEARCH, 32, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_DELETE, 16, 0, 0, 0), 0, '0});
    rows.insert(rows.size(), '{mk_cmd(OP_PRINT, 0, 0, 0, 0), 0, '0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 31 : (ph == 1) ? 77 : 0;
      rx_idle = (ph == 0) ? 77 : (ph == 1) ? 31 : 0;
      while (pending_q.size() != 0) @(negedge clk);
      for (int n = 0; n < 85; n++) begin
        if (n == 2 && ph != 1) long_hold = 1;
        send_cmd(rand_cmd(), 0, '0);
      end
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
